// File: sv/cole_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cole_pkg;
   localparam int DEF_CAPACITY = 256;
   localparam int KIND_W = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W = 9;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      K_APPEND = 3'd0,
      K_PUSH_FRONT = 3'd1,
      K_INSERT_AT = 3'd2,
      K_DROP_FRONT = 3'd3,
      K_DROP_END = 3'd4,
      K_DROP_AT = 3'd5,
      K_SEARCH = 3'd6,
      K_NONE = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL = 2'd3
   } status_type;
endpackage
`default_nettype wire

// File: sv/circular_ordered_list_engine.sv
// Response: refused, empty and unused requests answer from S_IDLE; appends and
//   pushes pass S_POP and S_ACT, front drops S_ACT and then S_DROP if needed.
// Throughput: one transaction at a time; the next is taken once the result
//   register is free.
// Reset: synchronous active high; afterwards a free-stack fill sweep over
//   all CAPACITY slots runs while req_stall is high.
`timescale 1ns / 1ps
`default_nettype none
module circular_ordered_list_engine
   import cole_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [POS_W-1:0]    req_position,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_found,
   output logic [POS_W-1:0]         rsp_count
);
   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [8:0] {
      S_FILL  = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_WALK  = 9'b000000100,
      S_WWAIT = 9'b000001000,
      S_POP   = 9'b000010000,
      S_ACT   = 9'b000100000,
      S_RDCUR = 9'b001000000,
      S_DROP  = 9'b010000000,
      S_SRCH  = 9'b100000000
   } state_type;

   // memories
   logic [VALUE_W-1:0] value_mem [CAPACITY];
   logic [SW-1:0]      link_mem  [CAPACITY];
   logic [SW-1:0]      free_mem  [CAPACITY];

   logic [SW-1:0] link_raddr, free_raddr, link_rd_ff, free_rd_ff, val_raddr;
   logic [VALUE_W-1:0] val_rd_ff;
   logic link_we, link_we2, free_we, val_we;
   logic [SW-1:0] link_waddr, link_wdata, link_waddr2, link_wdata2;
   logic [SW-1:0] free_waddr, free_wdata, val_waddr;

   state_type state_ff, state_in;
   logic [CW-1:0] free_top_ff, free_top_in, count_ff, count_in;
   logic [SW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [SW-1:0] cur_ff, cur_in, pre_ff, pre_in, new_ff, new_in;
   logic [CW-1:0] steps_ff, steps_in, idx_ff, idx_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic rsp_valid_ff, rsp_valid_in, found_ff, found_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SW-1:0] fill_ff, fill_in;

   // a single write to the value or free memory, up to two link writes
   always_ff @(posedge clock) begin
      if (val_we) value_mem[val_waddr] <= val_ff;
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (link_we2) link_mem[link_waddr2] <= link_wdata2;
      if (free_we) free_mem[free_waddr] <= free_wdata;
      link_rd_ff <= link_mem[link_raddr];
      free_rd_ff <= free_mem[free_raddr];
      val_rd_ff <= value_mem[val_raddr];
   end

   logic accept;
   logic full;
   assign req_stall = !(state_ff == S_IDLE) || rsp_valid_ff;
   assign accept = req_valid && !req_stall;
   assign full = (count_ff >= CW'(CAPACITY)) || (free_top_ff == '0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_found = found_ff;
   assign rsp_count = POS_W'(count_ff);

   always_comb begin
      state_in = state_ff; free_top_in = free_top_ff; count_in = count_ff;
      head_in = head_ff; tail_in = tail_ff; cur_in = cur_ff; pre_in = pre_ff;
      new_in = new_ff; steps_in = steps_ff; idx_in = idx_ff;
      kind_in = kind_ff; val_in = val_ff; pos_in = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      found_in = found_ff; status_in = status_ff; fill_in = fill_ff;
      link_we = 1'b0; link_we2 = 1'b0; free_we = 1'b0; val_we = 1'b0;
      link_waddr = '0; link_wdata = '0; link_waddr2 = '0; link_wdata2 = '0;
      free_waddr = '0; free_wdata = '0; val_waddr = new_ff;
      link_raddr = cur_ff; free_raddr = SW'(free_top_ff - 1'b1);
      val_raddr = cur_ff;
      case (state_ff)
         // load free stack with identity
         S_FILL: begin
            free_we = 1'b1; free_waddr = fill_ff; free_wdata = fill_ff;
            fill_in = fill_ff + 1'b1;
            if (fill_ff == SW'(CAPACITY - 1)) state_in = S_IDLE;
         end
         // decode the transaction
         S_IDLE: begin
            if (accept) begin
               kind_in = req_kind; val_in = req_value; pos_in = req_position;
               found_in = 1'b0; status_in = ST_OK; cur_in = head_ff;
               idx_in = '0; pre_in = head_ff;
               case (req_kind)
                  K_APPEND, K_PUSH_FRONT: begin
                     if (full) begin
                        status_in = ST_FULL; rsp_valid_in = 1'b1;
                     end else state_in = S_POP;
                  end
                  K_INSERT_AT: begin
                     if (32'(req_position) > 32'(count_ff)) begin
                        status_in = ST_BADPOS; rsp_valid_in = 1'b1;
                     end else if (full) begin
                        status_in = ST_FULL; rsp_valid_in = 1'b1;
                     end else if (req_position == '0 ||
                                  CW'(req_position) == count_ff) begin
                        state_in = S_POP;
                     end else begin
                        steps_in = CW'(req_position - 1'b1); state_in = S_WALK;
                     end
                  end
                  K_DROP_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY; rsp_valid_in = 1'b1;
                     end else state_in = S_ACT;
                  end
                  K_DROP_END: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY; rsp_valid_in = 1'b1;
                     end else if (count_ff == CW'(1)) state_in = S_ACT;
                     else begin
                        steps_in = count_ff - CW'(2); state_in = S_WALK;
                     end
                  end
                  K_DROP_AT: begin
                     if (32'(req_position) >= 32'(count_ff)) begin
                        status_in = ST_BADPOS; rsp_valid_in = 1'b1;
                     end else if (req_position == '0) state_in = S_ACT;
                     else begin
                        steps_in = CW'(req_position - 1'b1); state_in = S_WALK;
                     end
                  end
                  K_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY; rsp_valid_in = 1'b1;
                     end else state_in = S_SRCH;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         // walk to predecessor: read link of cur, wait, advance
         S_WALK: begin
            if (idx_ff == steps_ff) begin
               pre_in = cur_ff;
               state_in = (kind_ff == K_INSERT_AT) ? S_POP : S_RDCUR;
            end else state_in = S_WWAIT;
         end
         S_WWAIT: begin
            cur_in = link_rd_ff; idx_in = idx_ff + 1'b1; state_in = S_WALK;
         end
         // pop a free slot, read pre's link
         S_POP: begin
            link_raddr = pre_ff;
            free_top_in = free_top_ff - 1'b1;
            state_in = S_ACT;
         end
         S_RDCUR: begin
            // link_rd_ff holds link of pre; read link of that entry next
            cur_in = link_rd_ff; link_raddr = link_rd_ff; state_in = S_DROP;
         end
         // add an entry, or drop front
         S_ACT: begin
            rsp_valid_in = 1'b1; state_in = S_IDLE;
            case (kind_ff)
               K_DROP_FRONT, K_DROP_END, K_DROP_AT: begin
                  free_we = 1'b1; free_waddr = SW'(free_top_ff);
                  free_wdata = head_ff; free_top_in = free_top_ff + 1'b1;
                  if (count_ff <= CW'(1)) begin
                     head_in = '0; tail_in = '0; count_in = '0;
                  end else begin
                     // need link of head: read it first
                     link_raddr = head_ff; rsp_valid_in = 1'b0;
                     free_we = 1'b0; free_top_in = free_top_ff;
                     kind_in = K_NONE; state_in = S_DROP; cur_in = head_ff;
                  end
               end
               default: begin
                  val_we = 1'b1; val_waddr = free_rd_ff; new_in = free_rd_ff;
                  count_in = count_ff + 1'b1;
                  if (kind_ff == K_APPEND ||
                      (kind_ff == K_INSERT_AT && CW'(pos_ff) == count_ff &&
                       pos_ff != '0)) begin
                     link_we = 1'b1; link_waddr = free_rd_ff;
                     link_wdata = (count_ff == '0) ? free_rd_ff : head_ff;
                     if (count_ff == '0) head_in = free_rd_ff;
                     else begin
                        link_we2 = 1'b1; link_waddr2 = tail_ff;
                        link_wdata2 = free_rd_ff;
                     end
                     tail_in = free_rd_ff;
                  end else if (kind_ff == K_PUSH_FRONT || pos_ff == '0) begin
                     link_we = 1'b1; link_waddr = free_rd_ff;
                     link_wdata = (count_ff == '0) ? free_rd_ff : head_ff;
                     if (count_ff == '0) tail_in = free_rd_ff;
                     else begin
                        link_we2 = 1'b1; link_waddr2 = tail_ff;
                        link_wdata2 = free_rd_ff;
                     end
                     head_in = free_rd_ff;
                  end else begin
                     link_we = 1'b1; link_waddr = free_rd_ff;
                     link_wdata = link_rd_ff;
                     link_we2 = 1'b1; link_waddr2 = pre_ff;
                     link_wdata2 = free_rd_ff;
                  end
               end
            endcase
         end
         // unlink cur (after pre), or the head when kind was cleared
         S_DROP: begin
            rsp_valid_in = 1'b1; state_in = S_IDLE;
            free_we = 1'b1; free_waddr = SW'(free_top_ff); free_wdata = cur_ff;
            free_top_in = free_top_ff + 1'b1; count_in = count_ff - 1'b1;
            link_we = 1'b1;
            if (kind_ff == K_NONE) begin
               head_in = link_rd_ff; link_waddr = tail_ff;
               link_wdata = link_rd_ff;
            end else if (cur_ff == tail_ff) begin
               tail_in = pre_ff; link_waddr = pre_ff; link_wdata = head_ff;
            end else begin
               link_waddr = pre_ff; link_wdata = link_rd_ff;
            end
         end
         // compare each entry; the value is read the cycle after its address
         S_SRCH: begin
            if (idx_ff[0] == 1'b0) begin
               idx_in[0] = 1'b1;
            end else begin
               if (val_rd_ff == val_ff) begin
                  found_in = 1'b1; rsp_valid_in = 1'b1; state_in = S_IDLE;
               end else if (steps_ff == count_ff - 1'b1) begin
                  rsp_valid_in = 1'b1; state_in = S_IDLE;
               end
               idx_in[0] = 1'b0;
               cur_in = link_rd_ff; steps_in = steps_ff + 1'b1;
            end
            if (state_ff == S_SRCH && idx_ff == '0 && steps_ff == '0 &&
                cur_ff != head_ff) cur_in = head_ff;
         end
         default: state_in = S_IDLE;
      endcase
      if (accept && req_kind == K_SEARCH) begin
         steps_in = '0; idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FILL; fill_ff <= '0;
         free_top_ff <= CW'(CAPACITY); count_ff <= '0;
         head_ff <= '0; tail_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in;
         free_top_ff <= free_top_in; count_ff <= count_in;
         head_ff <= head_in; tail_ff <= tail_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; pre_ff <= pre_in; new_ff <= new_in;
      steps_ff <= steps_in; idx_ff <= idx_in; kind_ff <= kind_in;
      val_ff <= val_in; pos_ff <= pos_in; found_ff <= found_in;
      status_ff <= status_in;
   end

   // checks; a popped slot is counted only once the entry is linked in
   a_count_free: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_FILL && state_ff != S_ACT |->
         CW'(count_ff + free_top_ff) == CW'(CAPACITY))
      else $error("count and free stack disagree");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_count))
      else $error("response dropped while stalled");
   a_found_search: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> status_ff == ST_OK)
      else $error("found flag with bad status");
endmodule
`default_nettype wire
